// ----- rtl/ray_circle_intersection_top_macros.svh -----
// Assertion macros for the ray/circle intersection block.
// Used by the top level; no other dependencies.
`ifndef RAY_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`define RAY_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RCI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rci assertion failed");
`define RCI_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rci assertion failed");
`else
`define RCI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RCI_ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

// ----- rtl/rci_pkg.sv -----
// Shared types and constants for the ray/circle intersection block.
// No dependencies.
`default_nettype none
package rci_pkg;
   // output point format: signed Q16.4
   localparam int OUT_BITS = 20;
   localparam int OUT_FRAC = 4;
   localparam int OUT_MAX  = (1 << (OUT_BITS - 1)) - 1;
   localparam int OUT_MIN  = -(1 << (OUT_BITS - 1));

   // register indexes
   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_RADIUS   = 2'd2;

   // control that travels along with each square root stage
   typedef struct packed {
      logic valid;
      logic miss;
   } stage_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/ray_circle_intersection_top.sv -----
// Ray/circle intersection pipeline: top level.
// Depends on rci_pkg, rci_isqrt and ray_circle_intersection_top_macros.svh.
//
//   channel   direction   handshake          contents
//   req_      in          valid / stall      origin_x, origin_y, dir_x, dir_y
//   rsp_      out         valid / stall      hit, hit_x, hit_y
//   csr_      in          valid / ready      index, wdata
//
// One transaction enters per cycle while the output is not stalled; the square root
// resolves one result bit per stage (root width = 24 at default parameters).
// Reset clears all valid bits and the obstacle registers; csr_ready is always high.
// A stalled output freezes the whole pipeline and raises req_stall.
`default_nettype none
`include "ray_circle_intersection_top_macros.svh"
module ray_circle_intersection_top #(
   parameter int COORD_BITS    = 15,
   parameter int DIR_FRAC_BITS = 14
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [COORD_BITS-1:0]          req_origin_x,
   input  wire  signed [COORD_BITS-1:0]          req_origin_y,
   input  wire  signed [DIR_FRAC_BITS+1:0]       req_dir_x,
   input  wire  signed [DIR_FRAC_BITS+1:0]       req_dir_y,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [rci_pkg::OUT_BITS-1:0]   rsp_hit_x,
   output logic signed [rci_pkg::OUT_BITS-1:0]   rsp_hit_y,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [1:0]                            csr_index,
   input  wire  [COORD_BITS-1:0]                 csr_wdata
);
   localparam int CB   = COORD_BITS;
   localparam int FB   = DIR_FRAC_BITS;
   localparam int FW   = CB + 1;
   localparam int DW   = FB + 2;
   localparam int PW   = FW + DW;
   localparam int HSUM = PW + 1;
   localparam int HRW  = HSUM + 1;
   localparam int SH   = FB - 4;
   localparam int HW   = HRW - SH;
   localparam int CW   = 2 * FW + 1;
   localparam int C8W  = CW + 8;
   localparam int DSW  = ((2 * HW > C8W) ? 2 * HW : C8W) + 1;
   localparam int SQ   = DSW / 2;
   localparam int TW   = ((HW > SQ) ? HW : SQ) + 2;
   localparam int MW   = TW + DW;
   localparam int RSW  = MW + 1;
   localparam int PSW  = RSW - FB;
   localparam int POSW = ((PSW > CB + 4) ? PSW : CB + 4) + 1;
   localparam int SIDE_W = HW + 2 * CB + 2 * DW;

   // ---------------- configuration ----------------
   logic signed [CB-1:0] center_x_ff, center_y_ff;
   logic [CB-2:0]        radius_ff;

   assign csr_ready = 1'b1;

   // write obstacle registers; unknown index drops the write
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            rci_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            rci_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            rci_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata[CB-2:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline enable ----------------
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage 1: offset from centre
   logic                 v1_ff;
   logic signed [FW-1:0] fx_ff, fy_ff;
   logic signed [CB-1:0] r1_ff, ox1_ff, oy1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff  <= FW'(req_origin_x) - FW'(center_x_ff);
         fy_ff  <= FW'(req_origin_y) - FW'(center_y_ff);
         r1_ff  <= {1'b0, radius_ff};
         ox1_ff <= req_origin_x;
         oy1_ff <= req_origin_y;
         dx1_ff <= req_dir_x;
         dy1_ff <= req_dir_y;
      end
   end

   // stage 2: products
   logic                     v2_ff;
   logic signed [PW-1:0]     pdx_ff, pdy_ff;
   logic signed [2*FW-1:0]   fxx_ff, fyy_ff;
   logic signed [2*CB-1:0]   rr_ff;
   logic signed [CB-1:0]     ox2_ff, oy2_ff;
   logic signed [DW-1:0]     dx2_ff, dy2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pdx_ff <= fx_ff * dx1_ff;
         pdy_ff <= fy_ff * dy1_ff;
         fxx_ff <= fx_ff * fx_ff;
         fyy_ff <= fy_ff * fy_ff;
         rr_ff  <= r1_ff * r1_ff;
         ox2_ff <= ox1_ff;
         oy2_ff <= oy1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
      end
   end

   // stage 3: half_b rounded to Q.4, and c
   logic signed [HRW-1:0] hb_round;
   logic                  v3_ff;
   logic signed [HW-1:0]  hb3_ff;
   logic signed [CW-1:0]  c_ff;
   logic signed [CB-1:0]  ox3_ff, oy3_ff;
   logic signed [DW-1:0]  dx3_ff, dy3_ff;

   assign hb_round = HRW'(HSUM'(pdx_ff) + HSUM'(pdy_ff)) + HRW'(2 ** (SH - 1));

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hb3_ff <= hb_round[HRW-1:SH];
         c_ff   <= CW'(fxx_ff) + CW'(fyy_ff) - CW'(rr_ff);
         ox3_ff <= ox2_ff;
         oy3_ff <= oy2_ff;
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
      end
   end

   // stage 4: hb squared
   logic                   v4_ff;
   logic signed [2*HW-1:0] hbsq_ff;
   logic signed [C8W-1:0]  c8_ff;
   logic signed [HW-1:0]   hb4_ff;
   logic signed [CB-1:0]   ox4_ff, oy4_ff;
   logic signed [DW-1:0]   dx4_ff, dy4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         hbsq_ff <= hb3_ff * hb3_ff;
         c8_ff   <= {c_ff, 8'b0};
         hb4_ff  <= hb3_ff;
         ox4_ff  <= ox3_ff;
         oy4_ff  <= oy3_ff;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
      end
   end

   // stage 5: discriminant
   logic                  v5_ff;
   logic signed [DSW-1:0] disc_ff;
   logic signed [HW-1:0]  hb5_ff;
   logic signed [CB-1:0]  ox5_ff, oy5_ff;
   logic signed [DW-1:0]  dx5_ff, dy5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         disc_ff <= DSW'(hbsq_ff) - DSW'(c8_ff);
         hb5_ff  <= hb4_ff;
         ox5_ff  <= ox4_ff;
         oy5_ff  <= oy4_ff;
         dx5_ff  <= dx4_ff;
         dy5_ff  <= dy4_ff;
      end
   end

   // square root stages; a negative discriminant goes in as zero, marked miss
   rci_pkg::stage_ctl_type sq_in_ctl, sq_out_ctl;
   logic [DSW-2:0]         sq_rad;
   logic [SQ-1:0]          sq_root;
   logic [SIDE_W-1:0]      sq_side_in, sq_side_out;

   assign sq_in_ctl.valid = v5_ff;
   assign sq_in_ctl.miss  = disc_ff[DSW-1];
   assign sq_rad          = disc_ff[DSW-1] ? '0 : disc_ff[DSW-2:0];
   assign sq_side_in      = {hb5_ff, ox5_ff, oy5_ff, dx5_ff, dy5_ff};

   rci_isqrt #(
      .IN_W   (DSW - 1),
      .ROOT_W (SQ),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (sq_in_ctl),
      .in_rad   (sq_rad),
      .in_side  (sq_side_in),
      .out_ctl  (sq_out_ctl),
      .out_root (sq_root),
      .out_side (sq_side_out)
   );

   logic signed [HW-1:0] hb6;
   logic signed [CB-1:0] ox6, oy6;
   logic signed [DW-1:0] dx6, dy6;
   logic signed [SQ:0]   s6;
   logic signed [TW-1:0] t1, t2;

   assign {hb6, ox6, oy6, dx6, dy6} = sq_side_out;
   assign s6 = {1'b0, sq_root};
   assign t1 = -TW'(hb6) - TW'(s6);
   assign t2 = -TW'(hb6) + TW'(s6);

   // stage T: pick nearer non-negative t
   logic                 vt_ff, mt_ff;
   logic signed [TW-1:0] t_ff;
   logic signed [CB-1:0] oxt_ff, oyt_ff;
   logic signed [DW-1:0] dxt_ff, dyt_ff;

   always_ff @(posedge clock) begin
      if (reset) vt_ff <= 1'b0;
      else if (en) vt_ff <= sq_out_ctl.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mt_ff  <= sq_out_ctl.miss || (t1[TW-1] && t2[TW-1]);
         t_ff   <= t1[TW-1] ? t2 : t1;
         oxt_ff <= ox6;
         oyt_ff <= oy6;
         dxt_ff <= dx6;
         dyt_ff <= dy6;
      end
   end

   // stage M: step along the ray
   logic                 vm_ff, mm_ff;
   logic signed [MW-1:0] tdx_ff, tdy_ff;
   logic signed [CB-1:0] oxm_ff, oym_ff;

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else if (en) vm_ff <= vt_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mm_ff  <= mt_ff;
         tdx_ff <= t_ff * dxt_ff;
         tdy_ff <= t_ff * dyt_ff;
         oxm_ff <= oxt_ff;
         oym_ff <= oyt_ff;
      end
   end

   // final: round, add origin, saturate to Q16.4
   logic signed [RSW-1:0]    rx, ry;
   logic signed [PSW-1:0]    sx, sy;
   logic signed [CB+3:0]     ox16, oy16;
   logic signed [POSW-1:0]   px, py;
   logic signed [rci_pkg::OUT_BITS-1:0] qx, qy;

   assign rx   = RSW'(tdx_ff) + RSW'(2 ** (FB - 1));
   assign ry   = RSW'(tdy_ff) + RSW'(2 ** (FB - 1));
   assign sx   = rx[RSW-1:FB];
   assign sy   = ry[RSW-1:FB];
   assign ox16 = {oxm_ff, 4'b0};
   assign oy16 = {oym_ff, 4'b0};
   assign px   = POSW'(sx) + POSW'(ox16);
   assign py   = POSW'(sy) + POSW'(oy16);

   always_comb begin
      if (px > POSW'(rci_pkg::OUT_MAX))      qx = rci_pkg::OUT_BITS'(rci_pkg::OUT_MAX);
      else if (px < POSW'(rci_pkg::OUT_MIN)) qx = rci_pkg::OUT_BITS'(rci_pkg::OUT_MIN);
      else                                   qx = px[rci_pkg::OUT_BITS-1:0];
      if (py > POSW'(rci_pkg::OUT_MAX))      qy = rci_pkg::OUT_BITS'(rci_pkg::OUT_MAX);
      else if (py < POSW'(rci_pkg::OUT_MIN)) qy = rci_pkg::OUT_BITS'(rci_pkg::OUT_MIN);
      else                                   qy = py[rci_pkg::OUT_BITS-1:0];
   end

   // output register; hold while stalled
   logic                                rsp_valid_ff, rsp_hit_ff;
   logic signed [rci_pkg::OUT_BITS-1:0] rsp_hit_x_ff, rsp_hit_y_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= vm_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff   <= !mm_ff;
         rsp_hit_x_ff <= mm_ff ? '0 : qx;
         rsp_hit_y_ff <= mm_ff ? '0 : qy;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_hit_x_ff;
   assign rsp_hit_y = rsp_hit_y_ff;

   // ---------------- assertions ----------------
   `RCI_ASSERT_NOW(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   `RCI_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
                   rsp_hit_x == '0 && rsp_hit_y == '0)
   `RCI_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid && !vm_ff && !v1_ff)
endmodule
`default_nettype wire

// ----- rtl/rci_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on rci_pkg (stage_ctl_type).
`default_nettype none
module rci_isqrt #(
   parameter int IN_W   = 48,
   parameter int ROOT_W = 24,
   parameter int SIDE_W = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire  rci_pkg::stage_ctl_type in_ctl,
   input  wire  [IN_W-1:0]              in_rad,
   input  wire  [SIDE_W-1:0]            in_side,
   output rci_pkg::stage_ctl_type       out_ctl,
   output logic [ROOT_W-1:0]            out_root,
   output logic [SIDE_W-1:0]            out_side
);
   localparam int RW = 2 * ROOT_W + 1;

   rci_pkg::stage_ctl_type ctl_ff [ROOT_W];
   logic [RW-1:0]          rem_ff [ROOT_W];
   logic [ROOT_W-1:0]      root_ff [ROOT_W];
   logic [SIDE_W-1:0]      side_ff [ROOT_W];

   wire [RW-1:0]           rem_w [ROOT_W+1];
   wire [ROOT_W-1:0]       root_w [ROOT_W+1];

   assign rem_w[0]  = RW'(in_rad);
   assign root_w[0] = '0;

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_stage
         localparam int B = ROOT_W - 1 - k;
         logic [RW-1:0] cand;
         logic          take;

         assign rem_w[k+1]  = rem_ff[k];
         assign root_w[k+1] = root_ff[k];

         // trial subtract for result bit B
         assign cand = (RW'(root_w[k]) << (B + 1)) + (RW'(1) << (2 * B));
         assign take = rem_w[k] >= cand;

         // advance control
         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else if (en) begin
               ctl_ff[k] <= (k == 0) ? in_ctl : ctl_ff[(k == 0) ? 0 : k - 1];
            end
         end

         // advance payload
         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k - 1];
               if (take) begin
                  rem_ff[k]  <= rem_w[k] - cand;
                  root_ff[k] <= root_w[k] | (ROOT_W'(1) << B);
               end else begin
                  rem_ff[k]  <= rem_w[k];
                  root_ff[k] <= root_w[k];
               end
            end
         end
      end
   endgenerate

   assign out_ctl  = ctl_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];
endmodule
`default_nettype wire

// ----- sim/tb_ray_circle_intersection_top.sv -----
// Self-checking bench for the ray/circle intersection pipeline.
// Depends on rci_pkg and ray_circle_intersection_top; drives rays, checks hit points.
`default_nettype none
module tb_ray_circle_intersection_top;
   localparam int CB = 15;
   localparam int DB = 16;
   localparam int LATENCY = 40;
   localparam int WATCHDOG_LIMIT = 20000;
   // index past the register list; writes to it are dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic             hit;
      logic signed [19:0] hx;
      logic signed [19:0] hy;
   } hit_point_type;

   // scoreboard: predicts the hit point of each ray and checks it in order
   class hit_scoreboard;
      logic signed [CB-1:0] cx, cy;
      logic [CB-2:0]        rad;
      hit_point_type        pending_hits[$];
      int                   errors;
      int                   checked;
      int                   hits_seen;

      function new();
         cx = '0; cy = '0; rad = '0; errors = 0; checked = 0; hits_seen = 0;
      endfunction

      function void write_csr(logic [1:0] idx, logic [CB-1:0] val);
         if (idx == rci_pkg::CSR_CENTER_X) cx = val;
         else if (idx == rci_pkg::CSR_CENTER_Y) cy = val;
         else if (idx == rci_pkg::CSR_RADIUS) rad = val[CB-2:0];
      endfunction

      // floor((v + 2^(sh-1)) / 2^sh)
      function longint round_half_up(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      function longint int_sqrt(longint n);
         longint r;
         longint b;
         r = 0;
         for (int i = 31; i >= 0; i--) begin
            b = r | (longint'(1) << i);
            if (b * b <= n) r = b;
         end
         return r;
      endfunction

      function logic signed [19:0] saturate(longint v);
         if (v > rci_pkg::OUT_MAX) v = rci_pkg::OUT_MAX;
         if (v < rci_pkg::OUT_MIN) v = rci_pkg::OUT_MIN;
         return v[19:0];
      endfunction

      function void note_ray(logic signed [CB-1:0] ox, logic signed [CB-1:0] oy,
                             logic signed [DB-1:0] dx, logic signed [DB-1:0] dy);
         hit_point_type e;
         longint fx, fy, hb, c, disc, s, t, r;
         fx = longint'(ox) - longint'(cx);
         fy = longint'(oy) - longint'(cy);
         r = longint'(rad);
         hb = round_half_up(fx * longint'(dx) + fy * longint'(dy), DB - 2 - 4);
         c = fx * fx + fy * fy - r * r;
         disc = hb * hb - c * 256;
         e.hit = 1'b0; e.hx = '0; e.hy = '0;
         if (disc >= 0) begin
            s = int_sqrt(disc);
            t = -hb - s;
            if (t < 0) t = -hb + s;
            if (t >= 0) begin
               e.hit = 1'b1;
               e.hx = saturate(longint'(ox) * 16 + round_half_up(t * longint'(dx), DB - 2));
               e.hy = saturate(longint'(oy) * 16 + round_half_up(t * longint'(dy), DB - 2));
            end
         end
         pending_hits.push_back(e);
      endfunction

      function void check_result(logic h, logic signed [19:0] x, logic signed [19:0] y);
         hit_point_type e;
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected transaction hit=%0d x=%0d y=%0d", $time, h, x, y);
            errors++;
            return;
         end
         e = pending_hits.pop_front();
         checked++;
         if (h) hits_seen++;
         if (h !== e.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, h);
            errors++;
         end
         if (x !== e.hx) begin
            $display("%0t: hit_x expected %0d actual %0d", $time, e.hx, x);
            errors++;
         end
         if (y !== e.hy) begin
            $display("%0t: hit_y expected %0d actual %0d", $time, e.hy, y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_origin_x = '0, req_origin_y = '0;
   logic signed [DB-1:0] req_dir_x = '0, req_dir_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic signed [19:0] rsp_hit_x, rsp_hit_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   int send_idle_pct = 13;
   int recv_idle_pct = 53;
   int idle_cycles = 0;
   int rays_sent = 0;
   hit_scoreboard sb = new();

   ray_circle_intersection_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit), .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // check results and apply random backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_hit, rsp_hit_x, rsp_hit_y);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog: count cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", sb.pending_hits.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // drive one register write and hold it until taken; caller drops csr_valid
   task automatic write_reg(logic [1:0] idx, logic [CB-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_csr(idx, val);
   endtask

   task automatic set_obstacle(int x, int y, int r);
      write_reg(rci_pkg::CSR_CENTER_X, x[CB-1:0]);
      write_reg(rci_pkg::CSR_CENTER_Y, y[CB-1:0]);
      write_reg(rci_pkg::CSR_RADIUS, r[CB-1:0]);
      // an out-of-range index must be ignored
      write_reg(CSR_UNUSED, CB'($urandom));
      csr_valid <= 1'b0;
   endtask

   // hold one ray until accepted, with random gaps in front
   task automatic send_ray(int ox, int oy, int dx, int dy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= ox[CB-1:0];
      req_origin_y <= oy[CB-1:0];
      req_dir_x <= dx[DB-1:0];
      req_dir_y <= dy[DB-1:0];
      do @(posedge clock); while (req_stall);
      sb.note_ray(ox[CB-1:0], oy[CB-1:0], dx[DB-1:0], dy[DB-1:0]);
      rays_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // random ray starting near the obstacle, mostly unit-length directions
   task automatic random_ray(int cxi, int cyi, int r);
      real a;
      int ox, oy, dx, dy;
      ox = cxi + $signed($urandom_range(4 * r + 64)) - (2 * r + 32);
      oy = cyi + $signed($urandom_range(4 * r + 64)) - (2 * r + 32);
      if ($urandom_range(9) == 0) begin
         ox = $signed($urandom_range(32767)) - 16384;
         oy = $signed($urandom_range(32767)) - 16384;
      end
      if ($urandom_range(7) == 0) begin
         dx = $signed($urandom_range(65535)) - 32768;
         dy = $signed($urandom_range(65535)) - 32768;
      end else begin
         a = $urandom_range(62831) / 10000.0;
         dx = $rtoi($cos(a) * 16384.0);
         dy = $rtoi($sin(a) * 16384.0);
      end
      if (ox > 16383) ox = 16383;
      if (ox < -16384) ox = -16384;
      if (oy > 16383) oy = 16383;
      if (oy < -16384) oy = -16384;
      send_ray(ox, oy, dx, dy);
   endtask

   task automatic random_phase(int n, int cxi, int cyi, int r);
      for (int i = 0; i < n; i++) random_ray(cxi, cyi, r);
      drain();
   endtask

   initial begin
      int cxi, cyi, r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero-radius circle at the origin from reset
      send_ray(0, 0, 16384, 0);
      send_ray(5, 0, -16384, 0);
      drain();
      set_obstacle(100, 50, 20);
      send_ray(0, 50, 16384, 0);         // straight hit
      send_ray(0, 70, 16384, 0);         // tangent
      send_ray(0, 71, 16384, 0);         // near miss
      send_ray(0, 50, -16384, 0);        // behind the origin
      send_ray(100, 50, 0, 16384);       // origin inside: exit point
      send_ray(100, 50, 0, -16384);
      send_ray(0, 50, -32768, 0);        // most negative direction code
      send_ray(0, 50, 32767, 32767);     // non-unit direction
      send_ray(100, 0, 0, 16384);
      send_ray(-16384, -16384, 11585, 11585);
      send_ray(16383, 16383, -11585, -11585);
      drain();
      set_obstacle(-16384, -16384, 16383);  // extreme registers
      send_ray(16383, 16383, -16384, -16384);
      send_ray(16383, -16384, -32768, 32767);
      send_ray(-16384, 16383, 0, -16384);
      send_ray(0, 0, 16384, 16384);
      drain();
      set_obstacle(16383, 16383, 0);
      send_ray(16383, 16383, 16384, 0);
      send_ray(16383, 0, 0, 16384);
      send_ray(0, 16383, 32767, 0);
      drain();

      // random phases across several obstacles and idle profiles
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 53 : 0;
         recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 13 : 0;
         for (int k = 0; k < 4; k++) begin
            cxi = $signed($urandom_range(32767)) - 16384;
            cyi = $signed($urandom_range(32767)) - 16384;
            r = (k == 3) ? $urandom_range(16383) : $urandom_range(300);
            set_obstacle(cxi, cyi, r);
            random_phase(66, cxi, cyi, r);
         end
      end
      recv_idle_pct = 0;
      drain();

      $display("sent %0d rays over %0d checked results, %0d hits",
               rays_sent, sb.checked, sb.hits_seen);
      if (sb.errors == 0 && sb.pending_hits.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/rci_pkg.sv
rtl/rci_isqrt.sv
rtl/ray_circle_intersection_top.sv
sim/tb_ray_circle_intersection_top.sv
